// ===== design/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, skipped while in reset.
`define SPQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorted_priority_queue assertion failed");
// Clocked check that also holds during reset.
`define SPQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sorted_priority_queue assertion failed");
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/spq_pkg.sv =====
// Types and constants of the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int FILL_W = 5;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_FULL  = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [7:0]         prio;
    } entry_t;

    typedef struct packed {
        logic               command;
        logic signed [31:0] item_data;
        logic [7:0]         item_priority;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic signed [31:0]  out_data;
        logic [7:0]          out_priority;
        logic [FILL_W-1:0]   fill_count;
    } out_item_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic enq;
        logic deq;
        logic occ;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: a chain of compare-and-shift cells.
`default_nettype none
`include "assert_macros.svh"
// Sorted priority queue of DEPTH entries held in a row of cells, head in cell 0.
// Every cell compares its priority with the incoming entry in parallel. On an enqueue
// it keeps its entry, takes the new one or takes its left neighbor's; on a dequeue
// it takes its right neighbor's. busy never rises: an item is taken at every edge
// where start is high, and its result appears with result_valid for exactly one
// cycle, the cycle after the item was taken. The receiver cannot stall; results
// not captured in that cycle are lost. Equal priorities leave first-in first-out;
// an enqueue on a full queue reports full, a dequeue on an empty queue reports
// empty, and out_data/out_priority are zero except on a successful dequeue.
module sorted_priority_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  spq_pkg::in_item_t    item,
    output logic                 result_valid,
    output spq_pkg::out_item_t   result
);
    import spq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             result_valid_reg;
    out_item_t        result_reg;
    out_item_t        result_next;

    logic       accept;
    logic       full;
    logic       empty;
    logic       do_enq;
    logic       do_deq;
    entry_t     new_entry;
    entry_t     cell_entry [DEPTH];
    logic       cell_ge    [DEPTH];
    logic [CNT_W+FILL_W-1:0] fill_wide;

    assign busy         = 1'b0;
    assign accept       = start && !busy;
    assign full         = (count_reg == CNT_W'(DEPTH));
    assign empty        = (count_reg == '0);
    assign do_enq       = accept && (item.command == CMD_ENQ) && !full;
    assign do_deq       = accept && (item.command == CMD_DEQ) && !empty;
    assign new_entry    = '{data: item.item_data, prio: item.item_priority};
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            cell_ctrl_t ctrl;
            logic       l_ge;
            entry_t     l_entry;
            entry_t     r_entry;

            assign ctrl = '{enq: do_enq, deq: do_deq, occ: (count_reg > CNT_W'(g))};

            if (g == 0)
            begin : g_first
                assign l_ge    = 1'b1;
                assign l_entry = new_entry;
            end
            else
            begin : g_mid
                assign l_ge    = cell_ge[g-1];
                assign l_entry = cell_entry[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign r_entry = '0;
            end
            else
            begin : g_inner
                assign r_entry = cell_entry[g+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .left_ge     (l_ge),
                .left_entry  (l_entry),
                .right_entry (r_entry),
                .entry       (cell_entry[g]),
                .ge          (cell_ge[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign fill_wide = {{FILL_W{1'b0}}, count_next};

    always_comb
    begin
        result_next              = '0;
        result_next.fill_count   = fill_wide[FILL_W-1:0];
        if (item.command == CMD_ENQ)
        begin
            result_next.status = full ? ST_FULL : ST_ENQ;
        end
        else if (empty)
        begin
            result_next.status = ST_EMPTY;
        end
        else
        begin
            result_next.status       = ST_DEQ;
            result_next.out_data     = cell_entry[0].data;
            result_next.out_priority = cell_entry[0].prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    `SPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `SPQ_ASSERT(a_strobe_follows_accept, result_valid == $past(accept))
    `SPQ_ASSERT(a_deq_shrinks, do_deq |=> count_reg == $past(count_reg) - CNT_W'(1))
    `SPQ_ASSERT(a_enq_grows, do_enq |=> count_reg == $past(count_reg) + CNT_W'(1))
    `SPQ_ASSERT(a_head_order, (count_reg > CNT_W'(1)) |-> cell_entry[0].prio >= cell_entry[1].prio)

endmodule
`default_nettype wire

// ===== design/spq_cell.sv =====
// One slot of the sorted queue: compare against the new entry, keep or shift.
`default_nettype none
module spq_cell (
    input  wire                  clk,
    input  spq_pkg::cell_ctrl_t  ctrl,
    input  spq_pkg::entry_t      new_entry,
    input  wire                  left_ge,
    input  spq_pkg::entry_t      left_entry,
    input  spq_pkg::entry_t      right_entry,
    output spq_pkg::entry_t      entry,
    output logic                 ge
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Entry stays ahead of the new one when its priority is equal or higher.
    assign ge    = ctrl.occ && (entry_reg.prio >= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (!ge)
            begin
                // If the left neighbor stays put, this is the insertion slot; else shift in the left entry.
                entry_next = left_ge ? new_entry : left_entry;
            end
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire
